// ===== rtl/imh_pkg.sv =====
`default_nettype none
package imh_pkg;
    localparam int SLOTS    = 256;
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = 8;
    localparam int KEY_W    = 8;
    localparam int WGT_W    = 32;
    localparam int CNT_W    = 9;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_LOWERED  = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;
    localparam logic [1:0] ST_POPPED   = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [WGT_W-1:0] wgt;
    } entry_t;

    // memory requests from the sequencer to the store
    typedef struct packed {
        logic              heap_we;
        logic [ADDR_W-1:0] heap_waddr;
        entry_t            heap_wdata;
        logic [ADDR_W-1:0] heap_raddr;
        logic              pm_we;
        logic [KEY_W-1:0]  pm_waddr;
        logic [ADDR_W-1:0] pm_wdata;
        logic [KEY_W-1:0]  pm_raddr;
        logic              pm_clr;
        logic [KEY_W-1:0]  pm_caddr;
    } store_req_t;
endpackage
`default_nettype wire

// ===== rtl/indexed_min_heap_decrease_key.sv =====
`default_nettype none
// Indexed binary min-heap of up to 256 keys with signed Q16.16 weights and
// a key-to-slot map. op 0 inserts an absent key or lowers the weight of a
// present one (a weight that is not strictly smaller is ignored); op 1 pops
// the minimum. One request is handled at a time: s_ready is high only when
// the block is idle, and each request returns exactly one result on m_*.
// Work is done by a small sequencer around one heap memory with one read
// and one write port, one key-map memory and one shared signed comparator.
// Each heap level visited by a sift-down reads each child, compares them,
// then compares the lighter child with the sinking entry and writes the
// swap; after an insert or decrease the sift is rerun at each ancestor up
// to the root, while a pop sifts down once from the root.
module indexed_min_heap_decrease_key import imh_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_op,
    input  wire logic [KEY_W-1:0]        s_key,
    input  wire logic signed [WGT_W-1:0] s_weight,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_status,
    output logic                         m_pop_valid,
    output logic [KEY_W-1:0]             m_popped_key,
    output logic signed [WGT_W-1:0]      m_min_weight,
    output logic                         m_is_empty,
    output logic [CNT_W-1:0]             m_entry_count
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_DK    = 4'd2;
    localparam logic [3:0] S_PLGET = 4'd3;
    localparam logic [3:0] S_OUTER = 4'd4;
    localparam logic [3:0] S_SDLD  = 4'd5;
    localparam logic [3:0] S_SD    = 4'd6;
    localparam logic [3:0] S_RL    = 4'd7;
    localparam logic [3:0] S_RR    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_SDEND = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_FRD   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]               state_reg;
    logic                     op_reg;
    logic [KEY_W-1:0]         key_reg;
    logic signed [WGT_W-1:0]  w_reg;
    logic [CNT_W-1:0]         size_reg;
    logic [CNT_W-1:0]         p_reg;      // ancestor walk, node is p-1
    logic [ADDR_W-1:0]        pos_reg;    // current sift position
    logic [ADDR_W-1:0]        loc_reg;
    logic [ADDR_W-1:0]        m_reg;      // chosen child slot
    entry_t                   cur_reg;    // entry being sifted down
    entry_t                   lw_reg;     // left child
    entry_t                   child_reg;
    logic                     pop_mode_reg;
    logic [1:0]               status_reg;
    logic                     pvalid_reg;
    logic [KEY_W-1:0]         pkey_reg;

    store_req_t               req;
    entry_t                   heap_rd;
    logic [ADDR_W-1:0]        pm_rd;
    logic                     pm_present;

    imh_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .heap_rd    (heap_rd),
        .pm_rd      (pm_rd),
        .pm_present (pm_present)
    );

    // child slots of the current position
    logic [CNT_W:0] l_idx, r_idx;
    assign l_idx = {1'b0, pos_reg, 1'b1};
    assign r_idx = l_idx + (CNT_W+1)'(1);

    logic key_ok, slot_free;
    assign key_ok    = ({1'b0, key_reg} < (KEY_W+1)'(CAPACITY));
    assign slot_free = (size_reg < CNT_W'(SLOTS));

    // the one shared signed comparator: lt = a < b
    logic signed [WGT_W-1:0] cmp_a, cmp_b;
    logic                    lt;
    always_comb begin
        unique case (state_reg)
            S_RR:    begin cmp_a = lw_reg.wgt;    cmp_b = heap_rd.wgt; end
            S_CMP:   begin cmp_a = child_reg.wgt; cmp_b = cur_reg.wgt; end
            default: begin cmp_a = w_reg;         cmp_b = heap_rd.wgt; end
        endcase
    end
    assign lt = (cmp_a < cmp_b);

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        req = '0;
        unique case (state_reg)
            S_IDLE: begin
                req.pm_raddr = s_key;
            end
            S_LOOK: begin
                if (op_reg == OP_POP) begin
                    if (size_reg != '0) begin
                        req.pm_clr     = 1'b1;
                        req.pm_caddr   = heap_rd.key;
                        req.heap_raddr = ADDR_W'(size_reg - CNT_W'(1));
                    end
                end else if (key_ok && !pm_present && slot_free) begin
                    req.heap_we    = 1'b1;
                    req.heap_waddr = size_reg[ADDR_W-1:0];
                    req.heap_wdata = '{key: key_reg, wgt: w_reg};
                    req.pm_we      = 1'b1;
                    req.pm_waddr   = key_reg;
                    req.pm_wdata   = size_reg[ADDR_W-1:0];
                end else begin
                    req.heap_raddr = pm_rd;
                end
            end
            S_DK: begin
                if (lt) begin
                    req.heap_we    = 1'b1;
                    req.heap_waddr = loc_reg;
                    req.heap_wdata = '{key: heap_rd.key, wgt: w_reg};
                end
            end
            S_OUTER: begin
                req.heap_raddr = ADDR_W'(p_reg - CNT_W'(1));
            end
            S_SD: begin
                req.heap_raddr = l_idx[ADDR_W-1:0];
            end
            S_RL: begin
                req.heap_raddr = r_idx[ADDR_W-1:0];
            end
            S_CMP: begin
                if (lt) begin
                    req.heap_we    = 1'b1;
                    req.heap_waddr = pos_reg;
                    req.heap_wdata = child_reg;
                    req.pm_we      = 1'b1;
                    req.pm_waddr   = child_reg.key;
                    req.pm_wdata   = pos_reg;
                end
            end
            S_SDEND: begin
                req.heap_we    = 1'b1;
                req.heap_waddr = pos_reg;
                req.heap_wdata = cur_reg;
                req.pm_we      = 1'b1;
                req.pm_waddr   = cur_reg.key;
                req.pm_wdata   = pos_reg;
            end
            default: begin
                req.heap_raddr = '0;  // root for the result
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            size_reg  <= '0;
            m_valid   <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_op;
                        key_reg    <= s_key;
                        w_reg      <= s_weight;
                        pvalid_reg <= 1'b0;
                        pkey_reg   <= '0;
                        status_reg <= ST_IGNORED;
                        state_reg  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (op_reg == OP_POP) begin
                        status_reg <= ST_POPPED;
                        if (size_reg != '0) begin
                            pvalid_reg <= 1'b1;
                            pkey_reg   <= heap_rd.key;
                            size_reg   <= size_reg - CNT_W'(1);
                            state_reg  <= (size_reg == CNT_W'(1)) ? S_FIN : S_PLGET;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end else if (!key_ok) begin
                        state_reg <= S_FIN;
                    end else if (!pm_present) begin
                        if (slot_free) begin
                            status_reg <= ST_INSERTED;
                            size_reg   <= size_reg + CNT_W'(1);
                            p_reg      <= CNT_W'((size_reg + CNT_W'(1)) >> 1);
                            state_reg  <= S_OUTER;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end else begin
                        loc_reg   <= pm_rd;
                        state_reg <= S_DK;
                    end
                end
                S_DK: begin
                    if (lt) begin
                        status_reg <= ST_LOWERED;
                        p_reg      <= CNT_W'({1'b0, loc_reg}) + CNT_W'(1);
                        state_reg  <= S_OUTER;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_PLGET: begin
                    // last entry moves to the root and sinks
                    cur_reg      <= heap_rd;
                    pos_reg      <= '0;
                    pop_mode_reg <= 1'b1;
                    state_reg    <= S_SD;
                end
                S_OUTER: begin
                    state_reg <= (p_reg == '0) ? S_FIN : S_SDLD;
                    pos_reg   <= ADDR_W'(p_reg - CNT_W'(1));
                end
                S_SDLD: begin
                    cur_reg      <= heap_rd;
                    pop_mode_reg <= 1'b0;
                    state_reg    <= S_SD;
                end
                S_SD: begin
                    state_reg <= (l_idx >= {1'b0, size_reg}) ? S_SDEND : S_RL;
                end
                S_RL: begin
                    lw_reg <= heap_rd;
                    if (r_idx < {1'b0, size_reg}) begin
                        state_reg <= S_RR;
                    end else begin
                        child_reg <= heap_rd;
                        m_reg     <= l_idx[ADDR_W-1:0];
                        state_reg <= S_CMP;
                    end
                end
                S_RR: begin
                    // left wins only when strictly lighter
                    child_reg <= lt ? lw_reg : heap_rd;
                    m_reg     <= lt ? l_idx[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (lt) begin
                        pos_reg   <= m_reg;
                        state_reg <= S_SD;
                    end else begin
                        state_reg <= S_SDEND;
                    end
                end
                S_SDEND: begin
                    if (pop_mode_reg) begin
                        state_reg <= S_FIN;
                    end else begin
                        p_reg     <= p_reg >> 1;
                        state_reg <= S_OUTER;
                    end
                end
                S_FIN: begin
                    state_reg <= S_FRD;
                end
                S_FRD: begin
                    m_valid       <= 1'b1;
                    m_status      <= status_reg;
                    m_pop_valid   <= pvalid_reg;
                    m_popped_key  <= pkey_reg;
                    m_min_weight  <= (size_reg != '0) ? heap_rd.wgt : '0;
                    m_is_empty    <= (size_reg == '0);
                    m_entry_count <= size_reg;
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/imh_store.sv =====
`default_nettype none
module imh_store import imh_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire store_req_t        req,
    output entry_t                 heap_rd,
    output logic [ADDR_W-1:0]      pm_rd,
    output logic                   pm_present
);
    entry_t            heap_mem [SLOTS];
    logic [ADDR_W-1:0] pm_mem   [SLOTS];
    logic [SLOTS-1:0]  pm_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.heap_we) begin
            heap_mem[req.heap_waddr] <= req.heap_wdata;
        end
        heap_rd <= heap_mem[req.heap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.pm_we) begin
            pm_mem[req.pm_waddr] <= req.pm_wdata;
        end
        pm_rd <= pm_mem[req.pm_raddr];
    end

    // presence bits stand in for the absent marker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_vld_reg <= '0;
            pm_present <= 1'b0;
        end else begin
            if (req.pm_clr) begin
                pm_vld_reg[req.pm_caddr] <= 1'b0;
            end
            if (req.pm_we) begin
                pm_vld_reg[req.pm_waddr] <= 1'b1;
            end
            pm_present <= pm_vld_reg[req.pm_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== bench/tb_indexed_min_heap_decrease_key.sv =====
`default_nettype none
module tb_indexed_min_heap_decrease_key import imh_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  TAIL_CYCLES  = 400;   // > one full-heap insert
    localparam int  RAND_USEFUL  = 1200;  // plus 300: goal for non-ignored requests over the whole run

    typedef struct packed {
        logic [1:0]              status;
        logic                    pop_valid;
        logic [KEY_W-1:0]        popped_key;
        logic signed [WGT_W-1:0] min_weight;
        logic                    is_empty;
        logic [CNT_W-1:0]        entry_count;
    } heap_res_t;

    typedef struct packed {
        logic                    op;
        logic [KEY_W-1:0]        key;
        logic signed [WGT_W-1:0] weight;
        logic                    fixed;    // expected result typed in below
        heap_res_t               res;
    } dir_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_op;
    logic [KEY_W-1:0]        s_key;
    logic signed [WGT_W-1:0] s_weight;
    logic                    m_valid;
    logic                    m_ready;
    logic [1:0]              m_status;
    logic                    m_pop_valid;
    logic [KEY_W-1:0]        m_popped_key;
    logic signed [WGT_W-1:0] m_min_weight;
    logic                    m_is_empty;
    logic [CNT_W-1:0]        m_entry_count;

    indexed_min_heap_decrease_key i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_weight      (s_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_pop_valid   (m_pop_valid),
        .m_popped_key  (m_popped_key),
        .m_min_weight  (m_min_weight),
        .m_is_empty    (m_is_empty),
        .m_entry_count (m_entry_count)
    );

    // ------------------------------------------------------------------
    // Shadow heap: same layout and sift order as the block, so ties
    // resolve to the same keys.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]        sh_keys [SLOTS];
    logic signed [WGT_W-1:0] sh_wgts [SLOTS];
    int                      sh_slot [SLOTS];   // SLOTS marks an absent key
    int                      sh_size;

    heap_res_t expected_q[$];
    int        fail_n;
    int        req_n;       // requests accepted
    int        res_n;       // results accepted
    int        useful_n;    // accepted requests that were not ignored
    longint    cyc_n;

    // currently driven request may carry a typed expectation
    logic      cur_fixed;
    heap_res_t cur_res;

    // idle / stall knobs, flipped by phase so that quiet stretches occur
    logic      src_idle_on;
    logic      snk_stall_on;

    function automatic void heap_swap(int a, int b);
        logic [KEY_W-1:0]        tk;
        logic signed [WGT_W-1:0] tw;
        tk = sh_keys[a];
        tw = sh_wgts[a];
        sh_keys[a] = sh_keys[b];
        sh_wgts[a] = sh_wgts[b];
        sh_keys[b] = tk;
        sh_wgts[b] = tw;
        sh_slot[sh_keys[a]] = a;
        sh_slot[sh_keys[b]] = b;
    endfunction

    function automatic void heap_sift_down(int pos);
        int lc;
        int rc;
        int mc;
        while (pos < SLOTS) begin
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc >= sh_size) return;
            // left wins only when strictly lighter than right
            if (rc < sh_size) mc = (sh_wgts[lc] < sh_wgts[rc]) ? lc : rc;
            else mc = lc;
            if (!(sh_wgts[mc] < sh_wgts[pos])) return;
            heap_swap(pos, mc);
            pos = mc;
        end
    endfunction

    // sift at node p-1, then at every ancestor up to the root
    function automatic void heap_restore(int p);
        while (p > 0) begin
            heap_sift_down(p - 1);
            p = p / 2;
        end
    endfunction

    function automatic heap_res_t heap_apply(logic op, logic [KEY_W-1:0] key,
                                             logic signed [WGT_W-1:0] wgt);
        heap_res_t r;
        int        loc;
        r = '0;
        r.status = ST_IGNORED;
        if (op == OP_INSERT) begin
            loc = sh_slot[key];
            if (loc >= SLOTS) begin
                if (sh_size < SLOTS) begin
                    sh_keys[sh_size] = key;
                    sh_wgts[sh_size] = wgt;
                    sh_slot[key] = sh_size;
                    sh_size++;
                    heap_restore(sh_size / 2);
                    r.status = ST_INSERTED;
                end
            end else if (wgt < sh_wgts[loc]) begin
                sh_wgts[loc] = wgt;
                heap_restore(loc + 1);
                r.status = ST_LOWERED;
            end
        end else begin
            r.status = ST_POPPED;
            if (sh_size > 0) begin
                r.pop_valid  = 1'b1;
                r.popped_key = sh_keys[0];
                sh_slot[sh_keys[0]] = SLOTS;
                sh_size--;
                if (sh_size > 0) begin
                    sh_keys[0] = sh_keys[sh_size];
                    sh_wgts[0] = sh_wgts[sh_size];
                    sh_slot[sh_keys[0]] = 0;
                    heap_sift_down(0);
                end
            end
        end
        r.min_weight  = (sh_size > 0) ? sh_wgts[0] : '0;
        r.is_empty    = (sh_size == 0);
        r.entry_count = sh_size[CNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc_n <= cyc_n + 1;
        if (cyc_n > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still due", $time, expected_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side: predict on acceptance. Typed expectations win over the
    // shadow heap, which is still stepped so it stays in sync.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        heap_res_t p;
        if (aresetn && s_valid && s_ready) begin
            p = heap_apply(s_op, s_key, s_weight);
            if (p.status != ST_IGNORED) useful_n++;
            expected_q.push_back(cur_fixed ? cur_res : p);
            req_n++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: field by field against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        heap_res_t e;
        if (aresetn && m_valid && m_ready) begin
            res_n++;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d", $time, m_status);
                fail_n++;
            end else begin
                e = expected_q.pop_front();
                if (m_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, m_status);
                    fail_n++;
                end
                if (m_pop_valid !== e.pop_valid) begin
                    $display("%0t: pop_valid exp %0d got %0d", $time, e.pop_valid,
                             m_pop_valid);
                    fail_n++;
                end
                if (m_popped_key !== e.popped_key) begin
                    $display("%0t: popped_key exp %0d got %0d", $time, e.popped_key,
                             m_popped_key);
                    fail_n++;
                end
                if (m_min_weight !== e.min_weight) begin
                    $display("%0t: min_weight exp %0d got %0d", $time, e.min_weight,
                             m_min_weight);
                    fail_n++;
                end
                if (m_is_empty !== e.is_empty) begin
                    $display("%0t: is_empty exp %0d got %0d", $time, e.is_empty,
                             m_is_empty);
                    fail_n++;
                end
                if (m_entry_count !== e.entry_count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                             m_entry_count);
                    fail_n++;
                end
            end
        end
    end

    // Receiver: drops m_ready for a random stall before each result when stalls are on.
    initial begin
        int n;
        int seen;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            n = snk_stall_on ? $urandom_range(0, 18) : 0;
            seen = res_n;
            @(negedge aclk);
            m_ready = 1'b0;
            repeat (n) @(negedge aclk);
            m_ready = 1'b1;
            while (res_n == seen) @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_req(logic op, logic [KEY_W-1:0] key,
                            logic signed [WGT_W-1:0] wgt, logic fixed, heap_res_t fres);
        int gap;
        int seen;
        gap = src_idle_on ? $urandom_range(0, 18) : 0;
        repeat (gap) @(negedge aclk);
        seen      = req_n;
        s_op      = op;
        s_key     = key;
        s_weight  = wgt;
        cur_fixed = fixed;
        cur_res   = fres;
        s_valid   = 1'b1;
        do @(negedge aclk); while (req_n == seen);
        s_valid   = 1'b0;
        cur_fixed = 1'b0;
        s_op      = 1'($urandom_range(0, 1));
        s_key     = KEY_W'($urandom);
        s_weight  = $urandom;
    endtask

    task automatic send_plain(logic op, logic [KEY_W-1:0] key, logic signed [WGT_W-1:0] wgt);
        send_req(op, key, wgt, 1'b0, '0);
    endtask

    // hold off until the block has answered everything
    task automatic drain();
        while (expected_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic signed [WGT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3, 4: return $signed($urandom_range(0, 8)) - 4;   // ties
            default: return $urandom;
        endcase
    endfunction

    // an insert that targets a present key half the time (lower, equal, higher)
    task automatic send_touch();
        int slot;
        logic signed [WGT_W-1:0] w;
        if (sh_size > 0 && $urandom_range(0, 1) == 1) begin
            slot = $urandom_range(0, sh_size - 1);
            case ($urandom_range(0, 3))
                0:       w = sh_wgts[slot];
                1:       w = sh_wgts[slot] + $urandom_range(1, 100);
                default: w = sh_wgts[slot] - $urandom_range(1, 1 << $urandom_range(0, 20));
            endcase
            send_plain(OP_INSERT, sh_keys[slot], w);
        end else begin
            send_plain(OP_INSERT, KEY_W'($urandom), pick_weight());
        end
    endtask

    localparam logic signed [WGT_W-1:0] W_MAX = 32'sh7fff_ffff;
    localparam logic signed [WGT_W-1:0] W_MIN = 32'sh8000_0000;

    dir_row_t dir_tab[13];

    initial begin
        int perm [SLOTS];
        int j;
        int t;
        int pops;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_INSERT;
        s_key        = '0;
        s_weight     = '0;
        cur_fixed    = 1'b0;
        cur_res      = '0;
        src_idle_on  = 1'b1;
        snk_stall_on = 1'b1;
        fail_n = 0;
        req_n = 0;
        res_n = 0;
        useful_n = 0;
        cyc_n = 0;
        sh_size = 0;
        for (int i = 0; i < SLOTS; i++) sh_slot[i] = SLOTS;

        // op, key, weight, typed?, {status, pop_valid, key, min, empty, count}
        dir_tab = '{
            '{OP_POP,    8'd0,   32'sd0, 1'b1, '{ST_POPPED,   1'b0, 8'd0, 32'sd0, 1'b1, 9'd0}},
            '{OP_INSERT, 8'd0,   W_MAX,  1'b1, '{ST_INSERTED, 1'b0, 8'd0, W_MAX,  1'b0, 9'd1}},
            '{OP_INSERT, 8'd255, W_MIN,  1'b1, '{ST_INSERTED, 1'b0, 8'd0, W_MIN,  1'b0, 9'd2}},
            // present key, same weight: ignored
            '{OP_INSERT, 8'd0,   W_MAX,  1'b1, '{ST_IGNORED,  1'b0, 8'd0, W_MIN,  1'b0, 9'd2}},
            '{OP_INSERT, 8'd255, W_MIN,  1'b1, '{ST_IGNORED,  1'b0, 8'd0, W_MIN,  1'b0, 9'd2}},
            '{OP_INSERT, 8'd0,   32'sd0, 1'b0, '0},   // lowered
            '{OP_INSERT, 8'd17,  32'sd0, 1'b0, '0},   // tie with key 0
            '{OP_INSERT, 8'd18,  -32'sd1, 1'b0, '0},
            '{OP_POP,    8'd255, 32'sd0, 1'b0, '0},
            '{OP_POP,    8'd0,   W_MAX,  1'b0, '0},
            '{OP_POP,    8'd0,   32'sd0, 1'b0, '0},
            '{OP_POP,    8'd0,   32'sd0, 1'b0, '0},   // last entry leaves
            '{OP_POP,    8'd0,   32'sd0, 1'b1, '{ST_POPPED,   1'b0, 8'd0, 32'sd0, 1'b1, 9'd0}}
        };

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i])
            send_req(dir_tab[i].op, dir_tab[i].key, dir_tab[i].weight,
                     dir_tab[i].fixed, dir_tab[i].res);
        drain();   // sender pause until all results are back

        // fill the heap with every key in shuffled order, poke it, empty it
        src_idle_on  = 1'b0;
        snk_stall_on = 1'b0;
        for (int i = 0; i < SLOTS; i++) perm[i] = i;
        for (int i = SLOTS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 64) src_idle_on = 1'b1;
            if (i == 128) snk_stall_on = 1'b1;
            send_plain(OP_INSERT, perm[i][KEY_W-1:0], pick_weight());
        end
        repeat (40) send_touch();   // full heap: only lowers and ignores
        pops = sh_size;
        for (int i = 0; i < pops + 1; i++) send_plain(OP_POP, KEY_W'($urandom), $urandom);
        drain();

        // random part: alternating grow and shrink bias
        while (useful_n < RAND_USEFUL + 300) begin
            if ($urandom_range(0, 99) == 0) begin
                src_idle_on  = $urandom_range(0, 3) != 0;
                snk_stall_on = $urandom_range(0, 3) != 0;
            end
            if (((useful_n / 150) % 2 == 0) ? ($urandom_range(0, 9) < 7)
                                            : ($urandom_range(0, 9) < 3))
                send_touch();
            else
                send_plain(OP_POP, KEY_W'($urandom), $urandom);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_n == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
